### design/stq_pkg.sv
package stq_pkg;

  localparam int NTERMS = 10;

  // Series coefficients in Q.28, cosine and sin(x)/x, lowest order first.
  localparam logic signed [31:0] COS_COEF [NTERMS] = '{
    32'sd268435456,  -32'sd1073741824, 32'sd715827883, -32'sd190887435,
    32'sd27269634,   -32'sd2423967,    32'sd146907,    -32'sd6457,
    32'sd215,        -32'sd6
  };
  localparam logic signed [31:0] SIN_COEF [NTERMS] = '{
    32'sd268435456,  -32'sd357913941,  32'sd143165577, -32'sd27269634,
    32'sd3029959,    -32'sd220361,     32'sd11301,     -32'sd430,
    32'sd13,         32'sd0
  };

  // One item as it moves through the series evaluation.
  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] tw;
    logic        [28:0] vs;
    logic        [27:0] vt;
    logic signed [31:0] cs;
    logic signed [31:0] ss;
    logic signed [31:0] ct;
    logic signed [31:0] st;
  } stq_hrn_t;

  // Round half up and drop 28 fraction bits.
  function automatic logic signed [31:0] rnd28(input logic signed [61:0] a);
    logic signed [61:0] t;
    t = a + 62'sd134217728;
    return t[59:28];
  endfunction

endpackage

### design/swing_twist_to_quaternion_unit.sv
// Channel | Dir | Payload (tdata, lowest bits first)
// in_     | in  | swing_x[15:0], swing_y[31:16], twist_angle[47:32]
// out_    | out | quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
//
// One beat is accepted per cycle while the output is not stalled; each result passes
// one squaring stage, nine Horner stages and four product and rounding stages.
// The nine chained series multiplies set the depth.
// rst_n is synchronous and clears only the valid bits.
// A stalled output freezes every stage together, so no beat is lost or repeated.
module swing_twist_to_quaternion_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // swing_x, swing_y, twist_angle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // quat_w, quat_x, quat_y, quat_z
);
  import stq_pkg::*;

  logic               en;
  logic               v [NTERMS];
  stq_hrn_t           d [NTERMS];
  logic signed [15:0] qw, qx, qy, qz;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  stq_square u_square (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_sx     (signed'(in_tdata[15:0])),
    .in_sy     (signed'(in_tdata[31:16])),
    .in_tw     (signed'(in_tdata[47:32])),
    .out_valid (v[0]),
    .out_data  (d[0])
  );

  for (genvar i = 0; i < NTERMS - 1; i++) begin : g_horner
    stq_horner_step #(
      .IDX(NTERMS - 2 - i)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (v[i]),
      .in_data   (d[i]),
      .out_valid (v[i+1]),
      .out_data  (d[i+1])
    );
  end

  stq_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v[NTERMS-1]),
    .in_data   (d[NTERMS-1]),
    .out_valid (out_tvalid),
    .out_w     (qw),
    .out_x     (qx),
    .out_y     (qy),
    .out_z     (qz)
  );

  assign out_tdata = {qz, qy, qx, qw};

endmodule

### design/stq_square.sv
module stq_square (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] in_sx,
  input  logic signed [15:0] in_sy,
  input  logic signed [15:0] in_tw,
  output logic               out_valid,
  output stq_pkg::stq_hrn_t  out_data
);
  import stq_pkg::*;

  logic signed [31:0] sqx;
  logic signed [31:0] sqy;
  logic signed [31:0] sqt;
  logic        [32:0] sum;
  logic               valid_r;
  stq_hrn_t           data_r;
  stq_hrn_t           data_nxt;

  assign sqx = in_sx * in_sx;
  assign sqy = in_sy * in_sy;
  assign sqt = in_tw * in_tw;
  assign sum = {1'b0, sqx} + {1'b0, sqy};

  // Horner evaluation starts from the highest order coefficient.
  always_comb begin
    data_nxt    = '0;
    data_nxt.sx = in_sx;
    data_nxt.sy = in_sy;
    data_nxt.tw = in_tw;
    data_nxt.vs = sum[31:3];
    data_nxt.vt = sqt[30:3];
    data_nxt.cs = COS_COEF[NTERMS-1];
    data_nxt.ss = SIN_COEF[NTERMS-1];
    data_nxt.ct = COS_COEF[NTERMS-1];
    data_nxt.st = SIN_COEF[NTERMS-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### design/stq_horner_step.sv
module stq_horner_step #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  stq_pkg::stq_hrn_t in_data,
  output logic              out_valid,
  output stq_pkg::stq_hrn_t out_data
);
  import stq_pkg::*;

  logic signed [29:0] vs_s;
  logic signed [28:0] vt_s;
  logic signed [61:0] pcs;
  logic signed [61:0] pss;
  logic signed [61:0] pct;
  logic signed [61:0] pst;
  logic               valid_r;
  stq_hrn_t           data_r;
  stq_hrn_t           data_nxt;

  assign vs_s = signed'({1'b0, in_data.vs});
  assign vt_s = signed'({1'b0, in_data.vt});
  assign pcs  = in_data.cs * vs_s;
  assign pss  = in_data.ss * vs_s;
  assign pct  = in_data.ct * vt_s;
  assign pst  = in_data.st * vt_s;

  always_comb begin
    data_nxt    = in_data;
    data_nxt.cs = COS_COEF[IDX] + rnd28(pcs);
    data_nxt.ss = SIN_COEF[IDX] + rnd28(pss);
    data_nxt.ct = COS_COEF[IDX] + rnd28(pct);
    data_nxt.st = SIN_COEF[IDX] + rnd28(pst);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### design/stq_mix.sv
module stq_mix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  stq_pkg::stq_hrn_t  in_data,
  output logic               out_valid,
  output logic signed [15:0] out_w,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z
);
  import stq_pkg::*;

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    if (v > 24'sd32767) begin
      return 16'sh7fff;
    end else if (v < -24'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Stage A: sine of half twist.
  logic signed [47:0] stp;
  logic signed [47:0] stp_rnd;
  logic               va_r;
  logic signed [15:0] sx_a_r, sy_a_r;
  logic signed [31:0] cs_a_r, ss_a_r, ct_a_r, st_a_r;

  assign stp     = in_data.tw * in_data.st;
  assign stp_rnd = stp + 48'sd8192;

  // Stage B: rotated swing components.
  logic signed [48:0] axp, ayp;
  logic               vb_r;
  logic signed [31:0] cs_b_r, ss_b_r, st_b_r, ct_b_r;
  logic signed [33:0] ax_b_r, ay_b_r;

  assign axp = sx_a_r * ct_a_r + sy_a_r * st_a_r + 49'sd4096;
  assign ayp = sy_a_r * ct_a_r - sx_a_r * st_a_r + 49'sd4096;

  // Stage C: final products.
  logic               vc_r;
  logic signed [63:0] wp_c_r, zp_c_r;
  logic signed [65:0] xp_c_r, yp_c_r;

  // Stage D: rounding and saturation into the output register.
  logic signed [63:0] wr, zr;
  logic signed [65:0] xr, yr;
  logic               vd_r;
  logic signed [15:0] w_r, x_r, y_r, z_r;

  assign wr = wp_c_r + (64'sd1 <<< 41);
  assign zr = zp_c_r + (64'sd1 <<< 41);
  assign xr = xp_c_r + (66'sd1 <<< 42);
  assign yr = yp_c_r + (66'sd1 <<< 42);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_a_r <= in_data.sx;
      sy_a_r <= in_data.sy;
      cs_a_r <= in_data.cs;
      ss_a_r <= in_data.ss;
      ct_a_r <= in_data.ct;
      st_a_r <= stp_rnd[45:14];

      cs_b_r <= cs_a_r;
      ss_b_r <= ss_a_r;
      ct_b_r <= ct_a_r;
      st_b_r <= st_a_r;
      ax_b_r <= axp[46:13];
      ay_b_r <= ayp[46:13];

      wp_c_r <= cs_b_r * ct_b_r;
      zp_c_r <= cs_b_r * st_b_r;
      xp_c_r <= ss_b_r * ax_b_r;
      yp_c_r <= ss_b_r * ay_b_r;

      w_r <= sat16(24'(signed'(wr[63:42])));
      z_r <= sat16(24'(signed'(zr[63:42])));
      x_r <= sat16(24'(signed'(xr[65:43])));
      y_r <= sat16(24'(signed'(yr[65:43])));
    end
  end

  assign out_valid = vd_r;
  assign out_w     = w_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;

endmodule

### sim/swing_twist_to_quaternion_unit_tb.sv
`timescale 1ns / 100ps

module swing_twist_to_quaternion_unit_tb;

  typedef struct packed {
    logic signed [15:0] twist_angle;
    logic signed [15:0] swing_y;
    logic signed [15:0] swing_x;
  } pose_t;

  typedef struct packed {
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_w;
  } quat_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PIPE_DEPTH = 14;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  pose_t pending_poses[$];
  quat_t expected_quats[$];
  int    error_count = 0;
  int    idle_cycles = 0;
  bit    stimulus_done = 1'b0;
  int    send_wait = 0;
  int    recv_wait = 0;

  swing_twist_to_quaternion_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_shr(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return v[15:0];
  endfunction

  // Even power series in v = x^2/8 (Q.28): odd_term = 0 gives cos, 1 gives sin(x)/x.
  function automatic longint eval_series(longint v, bit odd_term);
    longint coef[10];
    longint fact;
    longint p;
    int k;
    fact = 1;
    k = 1;
    for (int n = 0; n < 10; n++) begin
      while (k <= 2 * n + odd_term) begin
        fact = fact * k;
        k++;
      end
      coef[n] = ((longint'(1) <<< (3 * n + 28)) + fact / 2) / fact;
      if (n % 2 == 1) coef[n] = -coef[n];
    end
    p = coef[9];
    for (int n = 8; n >= 0; n--) p = coef[n] + round_shr(p * v, 28);
    return p;
  endfunction

  function automatic quat_t pose_to_quat(pose_t p);
    longint sx, sy, tw, cs, ss, ct, st, ax, ay;
    quat_t q;
    sx = p.swing_x;
    sy = p.swing_y;
    tw = p.twist_angle;
    cs = eval_series(floor_shr(sx * sx + sy * sy, 3), 1'b0);
    ss = eval_series(floor_shr(sx * sx + sy * sy, 3), 1'b1);
    ct = eval_series(floor_shr(tw * tw, 3), 1'b0);
    st = round_shr(tw * eval_series(floor_shr(tw * tw, 3), 1'b1), 14);
    ax = round_shr(sx * ct + sy * st, 13);
    ay = round_shr(sy * ct - sx * st, 13);
    q.quat_w = clamp16(round_shr(cs * ct, 42));
    q.quat_x = clamp16(round_shr(ss * ax, 43));
    q.quat_y = clamp16(round_shr(ss * ay, 43));
    q.quat_z = clamp16(round_shr(cs * st, 42));
    return q;
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'(int'($urandom_range(0, 8192)) - 4096);
      2: return 16'(int'($urandom_range(0, 512)) - 256);
      3: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'(int'($urandom_range(0, 51472)) - 25736);
    endcase
  endfunction

  initial begin
    logic [15:0] corner[6];
    pose_t p;
    corner = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h3244};
    for (int i = 0; i < 6; i++) begin
      pending_poses.push_back('{twist_angle: corner[(i + 2) % 6], swing_y: corner[i],
                                swing_x: corner[5 - i]});
      pending_poses.push_back('{twist_angle: corner[i], swing_y: 16'h0, swing_x: 16'h0});
      pending_poses.push_back('{twist_angle: 16'h0, swing_y: corner[i], swing_x: corner[i]});
    end
    pending_poses.push_back('{twist_angle: 16'h8000, swing_y: 16'h8000, swing_x: 16'h8000});
    pending_poses.push_back('{twist_angle: 16'h7fff, swing_y: 16'h7fff, swing_x: 16'h7fff});
    for (int i = 0; i < 1750; i++) begin
      p.swing_x = pick_angle();
      p.swing_y = pick_angle();
      p.twist_angle = $urandom_range(0, 7) == 0 ? 16'h0 : pick_angle();
      pending_poses.push_back(p);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_poses.size() == 0 && !in_tvalid);
    wait (expected_quats.size() == 0);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    stimulus_done = 1'b1;
  end

  // Driver: holds valid until the beat is taken, then waits a random gap.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_quats.push_back(pose_to_quat(pose_t'(in_tdata)));
        send_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      end
      if (!in_tvalid || in_tready) begin
        if (send_wait > 0 || pending_poses.size() == 0) begin
          in_tvalid <= 1'b0;
          if (send_wait > 0) send_wait--;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_poses.pop_front();
        end
      end
    end
  end

  // Monitor: checks each result beat and draws the next stall.
  always @(posedge clk) begin
    quat_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_quats.size() == 0) begin
          $error("unexpected result beat %h", out_tdata);
          error_count++;
        end else begin
          want = expected_quats.pop_front();
          if (got.quat_w !== want.quat_w) begin
            $error("quat_w expected %0d actual %0d", want.quat_w, got.quat_w);
            error_count++;
          end
          if (got.quat_x !== want.quat_x) begin
            $error("quat_x expected %0d actual %0d", want.quat_x, got.quat_x);
            error_count++;
          end
          if (got.quat_y !== want.quat_y) begin
            $error("quat_y expected %0d actual %0d", want.quat_y, got.quat_y);
            error_count++;
          end
          if (got.quat_z !== want.quat_z) begin
            $error("quat_z expected %0d actual %0d", want.quat_z, got.quat_z);
            error_count++;
          end
        end
        recv_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      end
      if (recv_wait > 0) begin
        out_tready <= 1'b0;
        recv_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stimulus_done || idle_cycles >= WATCHDOG_LIMIT);
    if (stimulus_done && error_count == 0 && expected_quats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
